// File: hw/rtl/iirs_pkg.sv
package iirs_pkg;

  // Stack geometry
  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  // Field widths of the streams
  localparam int CMD_W   = 3;
  localparam int POS_W   = 5;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 5;
  localparam int STAT_W  = 2;

  // Width used to compare positions against the fill count
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_TOP   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_BOTTOM = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_POS    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REM_BOTTOM = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REM_POS    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd5;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  // What a cell does with its word
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,  // keep the word
    OP_LOAD = 2'd1,  // take the shared load bus
    OP_UP   = 2'd2,  // take the word of the cell below (entries move up)
    OP_DOWN = 2'd3   // take the word of the cell above (entries move down)
  } cell_op_e;

endpackage

// File: hw/rtl/iirs_cell.sv
module iirs_cell (
  input  logic                          clk_i,
  input  iirs_pkg::cell_op_e            op_i,
  input  logic [iirs_pkg::WORD_W-1:0]   load_i,
  input  logic [iirs_pkg::WORD_W-1:0]   below_i,
  input  logic [iirs_pkg::WORD_W-1:0]   above_i,
  output logic [iirs_pkg::WORD_W-1:0]   data_o
);

  logic [iirs_pkg::WORD_W-1:0] word_q;

  // one stack entry; payload only, no reset
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      iirs_pkg::OP_HOLD: word_q <= word_q;
      iirs_pkg::OP_LOAD: word_q <= load_i;
      iirs_pkg::OP_UP:   word_q <= below_i;
      iirs_pkg::OP_DOWN: word_q <= above_i;
      default:           word_q <= word_q;
    endcase
  end

  assign data_o = word_q;

endmodule

// File: hw/rtl/indexed_insert_remove_stack.sv
// Bounded stack of signed 32-bit words, numbered from the bottom at position 0,
// held in a row of cells that shift in parallel. Commands arrive on the slave
// stream (command in tuser, position and value in tdata); every edit returns
// one status request carrying the new count. A dump returns one request per
// held entry, bottom first, one per cycle while the master side takes them,
// with tlast on the final one (an empty stack returns one empty status); the
// row rotates by one cell per emitted entry and is back in order when the dump
// ends, each entry read out through the single cell-0 read tap. The next
// command is taken once the previous one's requests have all gone into the
// output register. Full, empty and out-of-range commands leave the stack
// unchanged and report their status. Entries come up undefined after reset;
// only positions below the count are ever read, so no clearing pass runs.
module indexed_insert_remove_stack (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side: tuser = command[2:0]
  //             tdata = position[4:0], value[36:5], zero pad[39:37]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [2:0]  s_axis_tuser,
  input  logic [39:0] s_axis_tdata,
  // master side: tuser = status[1:0]
  //              tdata = element[31:0], count[36:32], zero pad[39:37]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [1:0]  m_axis_tuser,
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  localparam int DEPTH = iirs_pkg::DEPTH;
  localparam int CNT_W = iirs_pkg::CNT_W;
  localparam int CMP_W = iirs_pkg::CMP_W;
  localparam int WORD_W = iirs_pkg::WORD_W;

  logic                            state_q, state_d;
  logic [CNT_W-1:0]                fill_q, fill_d;
  logic [CNT_W-1:0]                rem_q, rem_d;

  logic                            m_valid_q;
  logic [WORD_W-1:0]               out_elem_q, out_elem_d;
  logic [CNT_W-1:0]                out_cnt_q, out_cnt_d;
  logic [iirs_pkg::STAT_W-1:0]     out_st_q, out_st_d;
  logic                            out_last_q, out_last_d;
  logic                            out_load;

  logic                            slot_free;
  logic                            in_acc;
  logic [iirs_pkg::CMD_W-1:0]      cmd;
  logic [iirs_pkg::POS_W-1:0]      pos;
  logic [WORD_W-1:0]               val;
  logic [CMP_W-1:0]                pos_x;
  logic [CMP_W-1:0]                fill_x;

  logic                            ins_en, rem_en, rot_en;
  logic [CMP_W-1:0]                ins_pos, rem_pos;
  logic [WORD_W-1:0]               load_bus;

  iirs_pkg::cell_op_e              cell_op  [DEPTH];
  logic [WORD_W-1:0]               cell_data [DEPTH];

  // input unpacking
  assign cmd    = s_axis_tuser;
  assign pos    = s_axis_tdata[iirs_pkg::POS_W-1:0];
  assign val    = s_axis_tdata[iirs_pkg::POS_W +: WORD_W];
  assign pos_x  = CMP_W'(pos);
  assign fill_x = CMP_W'(fill_q);

  assign slot_free     = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && slot_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // command decode and sequencing
  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    rem_d      = rem_q;
    out_load   = 1'b0;
    out_elem_d = '0;
    out_cnt_d  = fill_q;
    out_st_d   = iirs_pkg::ST_OK;
    out_last_d = 1'b1;
    ins_en     = 1'b0;
    rem_en     = 1'b0;
    rot_en     = 1'b0;
    ins_pos    = '0;
    rem_pos    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (cmd)
            iirs_pkg::CMD_PUSH_TOP, iirs_pkg::CMD_INS_BOTTOM, iirs_pkg::CMD_INS_POS: begin
              out_load = 1'b1;
              priority case (cmd)
                iirs_pkg::CMD_PUSH_TOP:   ins_pos = fill_x;
                iirs_pkg::CMD_INS_BOTTOM: ins_pos = '0;
                default:                  ins_pos = pos_x;
              endcase
              if (fill_x == CMP_W'(DEPTH)) begin
                out_st_d = iirs_pkg::ST_FULL;
              end else if (ins_pos > fill_x) begin
                out_st_d = iirs_pkg::ST_RANGE;
              end else begin
                ins_en    = 1'b1;
                fill_d    = fill_q + 1'b1;
                out_cnt_d = fill_q + 1'b1;
              end
            end
            iirs_pkg::CMD_REM_BOTTOM, iirs_pkg::CMD_REM_POS: begin
              out_load = 1'b1;
              rem_pos  = (cmd == iirs_pkg::CMD_REM_BOTTOM) ? '0 : pos_x;
              if (fill_q == '0) begin
                out_st_d = iirs_pkg::ST_EMPTY;
              end else if (rem_pos >= fill_x) begin
                out_st_d = iirs_pkg::ST_RANGE;
              end else begin
                rem_en    = 1'b1;
                fill_d    = fill_q - 1'b1;
                out_cnt_d = fill_q - 1'b1;
              end
            end
            iirs_pkg::CMD_DUMP: begin
              if (fill_q == '0) begin
                out_load = 1'b1;
                out_st_d = iirs_pkg::ST_EMPTY;
              end else begin
                state_d = S_DUMP;
                rem_d   = fill_q;
              end
            end
            default: begin
              // unknown command: report current count, no change
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_elem_d = cell_data[0];
          out_last_d = (rem_q == CNT_W'(1));
          rot_en     = 1'b1;
          rem_d      = rem_q - 1'b1;
          if (rem_q == CNT_W'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // per-cell shift controls
  assign load_bus = ins_en ? val : cell_data[0];

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_op[i] = iirs_pkg::OP_HOLD;
      if (ins_en) begin
        if (CMP_W'(i) == ins_pos) begin
          cell_op[i] = iirs_pkg::OP_LOAD;
        end else if (CMP_W'(i) > ins_pos) begin
          cell_op[i] = iirs_pkg::OP_UP;
        end
      end else if (rem_en) begin
        if (CMP_W'(i) >= rem_pos) begin
          cell_op[i] = iirs_pkg::OP_DOWN;
        end
      end else if (rot_en) begin
        // bottom word wraps into the top held cell
        if (CMP_W'(i) == fill_x - 1'b1) begin
          cell_op[i] = iirs_pkg::OP_LOAD;
        end else if (CMP_W'(i) < fill_x) begin
          cell_op[i] = iirs_pkg::OP_DOWN;
        end
      end
    end
  end

  // row of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_W-1:0] below, above;
    if (g == 0) begin : g_bot
      assign below = '0;
    end else begin : g_mid_lo
      assign below = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_top
      assign above = '0;
    end else begin : g_mid_hi
      assign above = cell_data[g+1];
    end
    iirs_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[g]),
      .load_i  (load_bus),
      .below_i (below),
      .above_i (above),
      .data_o  (cell_data[g])
    );
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fill_q    <= '0;
      rem_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      rem_q   <= rem_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_elem_q <= out_elem_d;
      out_cnt_q  <= out_cnt_d;
      out_st_q   <= out_st_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {3'b000, iirs_pkg::COUNT_W'(out_cnt_q), out_elem_q};

endmodule

// File: dv/indexed_insert_remove_stack_test.sv
module indexed_insert_remove_stack_test;

  // Unused command codes: the block answers them with an ok status
  localparam logic [iirs_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [iirs_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  localparam int CLK_PERIOD     = 12;
  localparam int RANDOM_ITEMS   = 190;
  localparam int LONG_SINK_HOLD = 300;
  localparam int DRILL_ROWS     = 24;

  // One response as seen on the master side
  typedef struct packed {
    logic signed [iirs_pkg::WORD_W-1:0] element;
    logic [iirs_pkg::COUNT_W-1:0]       count;
    logic [iirs_pkg::STAT_W-1:0]        status;
    logic                               last;
  } stack_result_t;

  // Directed row: command, repeated reps times; typed rows carry the expected status
  typedef struct {
    logic [iirs_pkg::CMD_W-1:0]  cmd;
    int                          pos;
    logic [iirs_pkg::WORD_W-1:0] word;
    int                          reps;
    bit                          typed;
    logic [iirs_pkg::STAT_W-1:0] status;
    int                          count;
  } drill_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [2:0]  s_axis_tuser;
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [1:0]  m_axis_tuser;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  // Shadow copy of the stack and the responses still owed by the block
  logic signed [iirs_pkg::WORD_W-1:0] shadow_words [iirs_pkg::DEPTH];
  int                                 shadow_count;
  stack_result_t                      pending_results [$];

  int  mismatches;
  int  results_taken;
  bit  src_gaps_on;
  drill_row_t drill_table [DRILL_ROWS];

  indexed_insert_remove_stack dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int gap_length(bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [iirs_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(0, 11))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_status(logic [iirs_pkg::STAT_W-1:0] st);
    pending_results.push_back('{element: '0, count: iirs_pkg::COUNT_W'(shadow_count),
                                status: st, last: 1'b1});
  endfunction

  // Insert with entries at and above pos moving up
  function automatic logic [iirs_pkg::STAT_W-1:0] shadow_insert(
      int pos, logic [iirs_pkg::WORD_W-1:0] word);
    if (shadow_count >= iirs_pkg::DEPTH) return iirs_pkg::ST_FULL;
    if (pos > shadow_count) return iirs_pkg::ST_RANGE;
    for (int i = shadow_count; i > pos; i--) shadow_words[i] = shadow_words[i-1];
    shadow_words[pos] = word;
    shadow_count++;
    return iirs_pkg::ST_OK;
  endfunction

  // Remove with entries above pos moving down
  function automatic logic [iirs_pkg::STAT_W-1:0] shadow_remove(int pos);
    if (shadow_count == 0) return iirs_pkg::ST_EMPTY;
    if (pos >= shadow_count) return iirs_pkg::ST_RANGE;
    for (int i = pos; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
    shadow_count--;
    return iirs_pkg::ST_OK;
  endfunction

  // Update the shadow stack and queue the responses a command causes
  function automatic void apply_stack_command(logic [iirs_pkg::CMD_W-1:0] cmd, int pos,
                                              logic [iirs_pkg::WORD_W-1:0] word);
    case (cmd)
      iirs_pkg::CMD_PUSH_TOP:   queue_status(shadow_insert(shadow_count, word));
      iirs_pkg::CMD_INS_BOTTOM: queue_status(shadow_insert(0, word));
      iirs_pkg::CMD_INS_POS:    queue_status(shadow_insert(pos, word));
      iirs_pkg::CMD_REM_BOTTOM: queue_status(shadow_remove(0));
      iirs_pkg::CMD_REM_POS:    queue_status(shadow_remove(pos));
      iirs_pkg::CMD_DUMP: begin
        if (shadow_count == 0) begin
          queue_status(iirs_pkg::ST_EMPTY);
        end else begin
          for (int i = 0; i < shadow_count; i++)
            pending_results.push_back('{element: shadow_words[i],
                                        count: iirs_pkg::COUNT_W'(shadow_count),
                                        status: iirs_pkg::ST_OK,
                                        last: (i + 1 == shadow_count)});
        end
      end
      default: queue_status(iirs_pkg::ST_OK);
    endcase
  endfunction

  // Offer one command after a random gap; returns at the edge that takes it
  task automatic offer_command(logic [iirs_pkg::CMD_W-1:0] cmd, int pos,
                               logic [iirs_pkg::WORD_W-1:0] word);
    int gap;
    gap = gap_length(src_gaps_on);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {3'b000, word, iirs_pkg::POS_W'(pos)};
    do @(posedge clk_i); while (!s_axis_tready);
    apply_stack_command(cmd, pos, word);
  endtask

  // Sender pauses until the block has answered everything
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Compare each taken response with the oldest expectation
  always @(posedge clk_i) begin
    stack_result_t got;
    stack_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_taken++;
      got = '{element: m_axis_tdata[31:0], count: m_axis_tdata[36:32],
              status: m_axis_tuser, last: m_axis_tlast};
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected response, expected none, got %h", $time, got);
      end else begin
        want = pending_results.pop_front();
        if (got.element !== want.element) begin
          mismatches++;
          $display("%0t: element expected %h got %h", $time, want.element, got.element);
        end
        if (got.count !== want.count) begin
          mismatches++;
          $display("%0t: count expected %0d got %0d", $time, want.count, got.count);
        end
        if (got.status !== want.status) begin
          mismatches++;
          $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
        end
        if (got.last !== want.last) begin
          mismatches++;
          $display("%0t: last expected %b got %b", $time, want.last, got.last);
        end
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold so the block backs up
  initial begin
    int  sink_hold;
    int  cycle_cnt;
    bit  sink_gaps_on;
    bit  backlog_done;
    sink_hold    = 0;
    cycle_cnt    = 0;
    sink_gaps_on = 1'b1;
    backlog_done = 1'b0;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      cycle_cnt++;
      if (cycle_cnt % 128 == 0) sink_gaps_on = ($urandom_range(0, 2) != 0);
      if (!backlog_done && results_taken >= 60) begin
        sink_hold    = LONG_SINK_HOLD;
        backlog_done = 1'b1;
      end else if (sink_hold == 0) begin
        sink_hold = gap_length(sink_gaps_on);
      end
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Stimulus: directed table, then random commands
  initial begin
    logic [iirs_pkg::CMD_W-1:0] cmd;
    int                         pos;
    int                         fill_bias;
    int                         r;
    drill_row_t                 row;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = '0;
    s_axis_tdata  = '0;
    mismatches    = 0;
    results_taken = 0;
    shadow_count  = 0;
    src_gaps_on   = 1'b1;
    fill_bias     = 50;

    drill_table = '{
      '{iirs_pkg::CMD_DUMP,       0,  32'h0000_0000, 1,  1'b1, iirs_pkg::ST_EMPTY, 0},
      '{iirs_pkg::CMD_REM_BOTTOM, 0,  32'h0000_0000, 1,  1'b1, iirs_pkg::ST_EMPTY, 0},
      '{iirs_pkg::CMD_REM_POS,    31, 32'h0000_0000, 1,  1'b1, iirs_pkg::ST_EMPTY, 0},
      '{iirs_pkg::CMD_INS_POS,    1,  32'h1234_5678, 1,  1'b1, iirs_pkg::ST_RANGE, 0},
      '{iirs_pkg::CMD_PUSH_TOP,   0,  32'h7fff_ffff, 1,  1'b1, iirs_pkg::ST_OK,    1},
      '{iirs_pkg::CMD_INS_BOTTOM, 0,  32'h8000_0000, 1,  1'b1, iirs_pkg::ST_OK,    2},
      '{iirs_pkg::CMD_INS_POS,    2,  32'hffff_ffff, 1,  1'b1, iirs_pkg::ST_OK,    3},
      '{iirs_pkg::CMD_INS_POS,    1,  32'h0000_0000, 1,  1'b1, iirs_pkg::ST_OK,    4},
      '{iirs_pkg::CMD_INS_POS,    31, 32'h5555_aaaa, 1,  1'b1, iirs_pkg::ST_RANGE, 4},
      '{iirs_pkg::CMD_REM_POS,    4,  32'h0000_0000, 1,  1'b1, iirs_pkg::ST_RANGE, 4},
      '{CMD_SPARE_7,              31, 32'hffff_ffff, 1,  1'b1, iirs_pkg::ST_OK,    4},
      '{iirs_pkg::CMD_DUMP,       0,  32'h0000_0000, 1,  1'b0, iirs_pkg::ST_OK,    0},
      '{iirs_pkg::CMD_REM_POS,    1,  32'h0000_0000, 1,  1'b1, iirs_pkg::ST_OK,    3},
      '{iirs_pkg::CMD_REM_BOTTOM, 0,  32'h0000_0000, 1,  1'b1, iirs_pkg::ST_OK,    2},
      '{iirs_pkg::CMD_PUSH_TOP,   0,  32'ha5a5_a5a5, 14, 1'b0, iirs_pkg::ST_OK,    0},
      '{iirs_pkg::CMD_PUSH_TOP,   0,  32'h0000_0001, 1,  1'b1, iirs_pkg::ST_FULL,  16},
      '{iirs_pkg::CMD_INS_BOTTOM, 0,  32'h0000_0002, 1,  1'b1, iirs_pkg::ST_FULL,  16},
      '{iirs_pkg::CMD_INS_POS,    31, 32'h0000_0003, 1,  1'b1, iirs_pkg::ST_FULL,  16},
      '{iirs_pkg::CMD_DUMP,       0,  32'h0000_0000, 1,  1'b0, iirs_pkg::ST_OK,    0},
      '{iirs_pkg::CMD_REM_POS,    15, 32'h0000_0000, 1,  1'b1, iirs_pkg::ST_OK,    15},
      '{iirs_pkg::CMD_REM_POS,    15, 32'h0000_0000, 1,  1'b1, iirs_pkg::ST_RANGE, 15},
      '{CMD_SPARE_6,              0,  32'h0000_0000, 1,  1'b1, iirs_pkg::ST_OK,    15},
      '{iirs_pkg::CMD_REM_POS,    0,  32'h0000_0000, 1,  1'b1, iirs_pkg::ST_OK,    14},
      '{iirs_pkg::CMD_DUMP,       0,  32'h0000_0000, 1,  1'b0, iirs_pkg::ST_OK,    0}
    };

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part; typed rows override the shadow's single status response
    for (int k = 0; k < DRILL_ROWS; k++) begin
      row = drill_table[k];
      for (int rep = 0; rep < row.reps; rep++) begin
        offer_command(row.cmd, row.pos, row.word ^ iirs_pkg::WORD_W'(rep));
        if (row.typed)
          pending_results[pending_results.size()-1] =
            '{element: '0, count: iirs_pkg::COUNT_W'(row.count), status: row.status,
              last: 1'b1};
      end
    end

    // Random part: phases lean toward filling or emptying the stack
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 30 == 0) begin
        fill_bias   = $urandom_range(15, 85);
        src_gaps_on = ($urandom_range(0, 3) != 0);
      end
      if (n == RANDOM_ITEMS / 2) drain_results();
      r = $urandom_range(0, 99);
      if (r < 4) begin
        cmd = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
      end else if (r < 14) begin
        cmd = iirs_pkg::CMD_DUMP;
      end else if ($urandom_range(0, 99) < fill_bias) begin
        case ($urandom_range(0, 2))
          0: cmd = iirs_pkg::CMD_PUSH_TOP;
          1: cmd = iirs_pkg::CMD_INS_BOTTOM;
          default: cmd = iirs_pkg::CMD_INS_POS;
        endcase
      end else begin
        cmd = $urandom_range(0, 1) ? iirs_pkg::CMD_REM_BOTTOM : iirs_pkg::CMD_REM_POS;
      end
      // Positions mostly legal, sometimes anything the field holds
      if ($urandom_range(0, 9) == 0)
        pos = $urandom_range(0, 31);
      else if (cmd == iirs_pkg::CMD_REM_POS)
        pos = (shadow_count > 0) ? $urandom_range(0, shadow_count - 1) : 0;
      else
        pos = $urandom_range(0, shadow_count);
      offer_command(cmd, pos, pick_word());
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(CLK_PERIOD * 600000);
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/iirs_pkg.sv
hw/rtl/iirs_cell.sv
hw/rtl/indexed_insert_remove_stack.sv
dv/indexed_insert_remove_stack_test.sv
